// ===== src/gbsp_pkg.sv =====
package gbsp_pkg;

   localparam int MAX_ENTRIES = 4096;
   localparam int MAX_GROUPS  = 128;

   localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
   localparam int ENTRY_CW = ENTRY_AW + 1;
   localparam int GROUP_AW = $clog2(MAX_GROUPS);
   localparam int GROUP_CW = GROUP_AW + 1;

   // request opcodes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_PICK  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // response status codes
   localparam logic [2:0] ST_LOADED  = 3'd0;
   localparam logic [2:0] ST_DROPPED = 3'd1;
   localparam logic [2:0] ST_PICKED  = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_QUOTA   = 3'd4;
   localparam logic [2:0] ST_CLEARED = 3'd5;

   // register indexes
   localparam logic CSR_GROUP_LIMIT = 1'b0;
   localparam logic CSR_PICK_QUOTA  = 1'b1;

   localparam logic [7:0] GROUP_LIMIT_RST = 8'd100;
   localparam logic [6:0] PICK_QUOTA_RST  = 7'd10;

   typedef struct packed {
      logic [1:0]         op;
      logic [31:0]        source_node;
      logic [31:0]        target_node;
      logic signed [31:0] edge_score;
      logic [6:0]         group_index;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [31:0]        picked_source;
      logic [31:0]        picked_target;
      logic signed [31:0] picked_score;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_META,
      S_SCAN,
      S_FETCH,
      S_REPORT
   } state_type;

endpackage

// ===== src/grouped_best_score_picker_top.sv =====
// Grouped best-score picker.
// Request channel: req_word is taken at a clock edge with start high and busy low.
// A load word appends an edge to the entry memory; a new source opens a new group.
// A pick word returns the best-scoring edge of one group and zeroes its score.
// A clear empties the group table and entry count; memories and registers stay.
// Response channel: rsp_strobe is high for one cycle with rsp_word; the receiver
// cannot stall, so every response is taken in the cycle it appears.
// Load and clear: the response is registered and appears in the cycle after the
// request; busy stays low, so a new request may follow in the next cycle.
// Pick: busy while the request runs through the states META, SCAN, FETCH and
// REPORT; the response is registered from REPORT. One compare unit walks the group
// one entry a cycle through the score memory read port. A pick of a group that is
// not open answers from IDLE without going busy; one past its quota, from META.
// Write csr_ port registers only while idle; the block does not enforce it.
// Reset (synchronous) empties the group table and restores the register defaults;
// entry memory contents are left as they are.
module grouped_best_score_picker_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  gbsp_pkg::req_type  req_word,
   output logic               rsp_strobe,
   output gbsp_pkg::rsp_type  rsp_word,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [7:0]         csr_wdata
);

   localparam int EAW = gbsp_pkg::ENTRY_AW;
   localparam int ECW = gbsp_pkg::ENTRY_CW;
   localparam int GAW = gbsp_pkg::GROUP_AW;
   localparam int GCW = gbsp_pkg::GROUP_CW;

   // configuration
   logic [7:0] group_limit_ff;
   logic [6:0] pick_quota_ff;

   // control state
   gbsp_pkg::state_type state_ff, state_in;
   logic [ECW-1:0]        entries_ff, entries_in;
   logic [GCW-1:0]        groups_ff, groups_in;
   logic [31:0]           prev_src_ff, prev_src_in;
   logic [ECW-1:0]        cur_count_ff, cur_count_in;
   logic [gbsp_pkg::MAX_GROUPS-1:0] group_valid_ff, group_valid_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   // pick working registers
   logic [GAW-1:0]        grp_ff, grp_in;
   logic [6:0]            picks_ff, picks_in;
   logic [EAW-1:0]        issue_addr_ff, issue_addr_in;
   logic [ECW-1:0]        issue_left_ff, issue_left_in;
   logic [EAW-1:0]        cmp_addr_ff, cmp_addr_in;
   logic [EAW-1:0]        best_addr_ff, best_addr_in;
   logic signed [31:0]    best_score_ff, best_score_in;
   logic                  best_valid_ff, best_valid_in;
   gbsp_pkg::rsp_type     rsp_word_ff, rsp_word_in;

   // memories
   logic [31:0]        src_mem   [gbsp_pkg::MAX_ENTRIES];
   logic [31:0]        tgt_mem   [gbsp_pkg::MAX_ENTRIES];
   logic signed [31:0] score_mem [gbsp_pkg::MAX_ENTRIES];
   logic [EAW-1:0]     first_mem [gbsp_pkg::MAX_GROUPS];
   logic [ECW-1:0]     count_mem [gbsp_pkg::MAX_GROUPS];
   logic [6:0]         picks_mem [gbsp_pkg::MAX_GROUPS];

   logic [31:0]        src_rd_ff, tgt_rd_ff;
   logic signed [31:0] score_rd_ff;
   logic [EAW-1:0]     first_rd_ff;
   logic [ECW-1:0]     count_rd_ff;
   logic [6:0]         picks_rd_ff;

   logic               ent_we;
   logic [EAW-1:0]     ent_waddr, ent_raddr;
   logic               score_we;
   logic [EAW-1:0]     score_waddr, score_raddr;
   logic signed [31:0] score_wd;
   logic               first_we, count_we, picks_we;
   logic [GAW-1:0]     meta_waddr, picks_waddr, meta_raddr;
   logic [ECW-1:0]     count_wd;
   logic [6:0]         picks_wd;

   // load decode
   logic               accept;
   logic               mem_full;
   logic               opens_group;
   logic               over_limit;
   logic [31:0]        limit_eff;
   logic [GAW-1:0]     req_grp;
   logic               req_grp_ok;

   assign accept      = start && (state_ff == gbsp_pkg::S_IDLE);
   assign mem_full    = (32'(entries_ff) >= 32'(gbsp_pkg::MAX_ENTRIES));
   assign opens_group = (groups_ff == '0) || (req_word.source_node != prev_src_ff);
   assign limit_eff   = (32'(group_limit_ff) < 32'(gbsp_pkg::MAX_GROUPS)) ?
                        32'(group_limit_ff) : 32'(gbsp_pkg::MAX_GROUPS);
   assign over_limit  = (32'(groups_ff) >= limit_eff);
   assign req_grp     = GAW'(req_word.group_index);
   assign req_grp_ok  = (32'(req_word.group_index) < 32'(gbsp_pkg::MAX_GROUPS)) &&
                        group_valid_ff[req_grp];

   always_ff @(posedge clock) begin
      if (reset) begin
         group_limit_ff <= gbsp_pkg::GROUP_LIMIT_RST;
         pick_quota_ff  <= gbsp_pkg::PICK_QUOTA_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            gbsp_pkg::CSR_GROUP_LIMIT: group_limit_ff <= csr_wdata;
            gbsp_pkg::CSR_PICK_QUOTA:  pick_quota_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= gbsp_pkg::S_IDLE;
         entries_ff     <= '0;
         groups_ff      <= '0;
         prev_src_ff    <= '0;
         group_valid_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entries_ff     <= entries_in;
         groups_ff      <= groups_in;
         prev_src_ff    <= prev_src_in;
         group_valid_ff <= group_valid_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_count_ff  <= cur_count_in;
      grp_ff        <= grp_in;
      picks_ff      <= picks_in;
      issue_addr_ff <= issue_addr_in;
      issue_left_ff <= issue_left_in;
      cmp_addr_ff   <= cmp_addr_in;
      best_addr_ff  <= best_addr_in;
      best_score_ff <= best_score_in;
      best_valid_ff <= best_valid_in;
      rsp_word_ff   <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         src_mem[ent_waddr] <= ent_we ? req_word.source_node : '0;
         tgt_mem[ent_waddr] <= req_word.target_node;
      end
      src_rd_ff <= src_mem[ent_raddr];
      tgt_rd_ff <= tgt_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (score_we) begin
         score_mem[score_waddr] <= score_wd;
      end
      score_rd_ff <= score_mem[score_raddr];
   end

   always_ff @(posedge clock) begin
      if (first_we) begin
         first_mem[meta_waddr] <= entries_ff[EAW-1:0];
      end
      if (count_we) begin
         count_mem[meta_waddr] <= count_wd;
      end
      if (picks_we) begin
         picks_mem[picks_waddr] <= picks_wd;
      end
      first_rd_ff <= first_mem[meta_raddr];
      count_rd_ff <= count_mem[meta_raddr];
      picks_rd_ff <= picks_mem[meta_raddr];
   end

   always_comb begin
      state_in       = state_ff;
      entries_in     = entries_ff;
      groups_in      = groups_ff;
      prev_src_in    = prev_src_ff;
      cur_count_in   = cur_count_ff;
      group_valid_in = group_valid_ff;
      rsp_strobe_in  = 1'b0;
      rsp_word_in    = '0;
      grp_in         = grp_ff;
      picks_in       = picks_ff;
      issue_addr_in  = issue_addr_ff;
      issue_left_in  = issue_left_ff;
      cmp_addr_in    = cmp_addr_ff;
      best_addr_in   = best_addr_ff;
      best_score_in  = best_score_ff;
      best_valid_in  = best_valid_ff;

      ent_we      = 1'b0;
      ent_waddr   = entries_ff[EAW-1:0];
      ent_raddr   = best_addr_ff;
      score_we    = 1'b0;
      score_waddr = entries_ff[EAW-1:0];
      score_wd    = req_word.edge_score;
      score_raddr = issue_addr_ff;
      first_we    = 1'b0;
      count_we    = 1'b0;
      picks_we    = 1'b0;
      meta_waddr  = groups_ff[GAW-1:0];
      picks_waddr = groups_ff[GAW-1:0];
      meta_raddr  = req_grp;
      count_wd    = ECW'(1);
      picks_wd    = '0;

      unique case (state_ff)
         gbsp_pkg::S_IDLE: begin
            if (accept) begin
               case (req_word.op)
                  gbsp_pkg::OP_LOAD: begin
                     rsp_strobe_in = 1'b1;
                     if (mem_full || (opens_group && over_limit)) begin
                        rsp_word_in.status = gbsp_pkg::ST_DROPPED;
                     end else begin
                        rsp_word_in.status = gbsp_pkg::ST_LOADED;
                        ent_we     = 1'b1;
                        score_we   = 1'b1;
                        count_we   = 1'b1;
                        entries_in = entries_ff + ECW'(1);
                        if (opens_group) begin
                           first_we     = 1'b1;
                           picks_we     = 1'b1;
                           cur_count_in = ECW'(1);
                           groups_in    = groups_ff + GCW'(1);
                           prev_src_in  = req_word.source_node;
                           group_valid_in[groups_ff[GAW-1:0]] = 1'b1;
                        end else begin
                           meta_waddr   = GAW'(groups_ff - GCW'(1));
                           count_wd     = cur_count_ff + ECW'(1);
                           cur_count_in = count_wd;
                        end
                     end
                  end
                  gbsp_pkg::OP_PICK: begin
                     if (req_grp_ok) begin
                        grp_in   = req_grp;
                        state_in = gbsp_pkg::S_META;
                     end else begin
                        rsp_strobe_in      = 1'b1;
                        rsp_word_in.status = gbsp_pkg::ST_EMPTY;
                     end
                  end
                  gbsp_pkg::OP_CLEAR: begin
                     entries_in         = '0;
                     groups_in          = '0;
                     prev_src_in        = '0;
                     group_valid_in     = '0;
                     rsp_strobe_in      = 1'b1;
                     rsp_word_in.status = gbsp_pkg::ST_CLEARED;
                  end
                  default: ;
               endcase
            end
         end
         gbsp_pkg::S_META: begin
            if (picks_rd_ff >= pick_quota_ff) begin
               rsp_strobe_in      = 1'b1;
               rsp_word_in.status = gbsp_pkg::ST_QUOTA;
               state_in           = gbsp_pkg::S_IDLE;
            end else begin
               // issue the group's first entry
               score_raddr   = first_rd_ff;
               cmp_addr_in   = first_rd_ff;
               issue_addr_in = first_rd_ff + EAW'(1);
               issue_left_in = count_rd_ff - ECW'(1);
               picks_in      = picks_rd_ff;
               best_valid_in = 1'b0;
               state_in      = gbsp_pkg::S_SCAN;
            end
         end
         gbsp_pkg::S_SCAN: begin
            // strict compare keeps the lowest index on ties
            if (!best_valid_ff || (score_rd_ff > best_score_ff)) begin
               best_addr_in  = cmp_addr_ff;
               best_score_in = score_rd_ff;
               best_valid_in = 1'b1;
            end
            if (issue_left_ff != '0) begin
               cmp_addr_in   = issue_addr_ff;
               issue_addr_in = issue_addr_ff + EAW'(1);
               issue_left_in = issue_left_ff - ECW'(1);
            end else begin
               state_in = gbsp_pkg::S_FETCH;
            end
         end
         gbsp_pkg::S_FETCH: begin
            ent_raddr = best_addr_ff;
            state_in  = gbsp_pkg::S_REPORT;
         end
         gbsp_pkg::S_REPORT: begin
            score_we    = 1'b1;
            score_waddr = best_addr_ff;
            score_wd    = '0;
            picks_we    = 1'b1;
            picks_waddr = grp_ff;
            picks_wd    = picks_ff + 7'd1;
            rsp_strobe_in             = 1'b1;
            rsp_word_in.status        = gbsp_pkg::ST_PICKED;
            rsp_word_in.picked_source = src_rd_ff;
            rsp_word_in.picked_target = tgt_rd_ff;
            rsp_word_in.picked_score  = best_score_ff;
            state_in                  = gbsp_pkg::S_IDLE;
         end
         default: state_in = gbsp_pkg::S_IDLE;
      endcase
   end

   assign busy       = (state_ff != gbsp_pkg::S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   a_valid_tracks_groups: assert property (@(posedge clock) disable iff (reset)
      $countones(group_valid_ff) == 32'(groups_ff))
      else $error("group valid bits disagree with group count");

   a_counters_bounded: assert property (@(posedge clock) disable iff (reset)
      (32'(entries_ff) <= 32'(gbsp_pkg::MAX_ENTRIES)) &&
      (32'(groups_ff) <= 32'(gbsp_pkg::MAX_GROUPS)))
      else $error("entry or group counter past capacity");

   a_picked_after_scan: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_word.status == gbsp_pkg::ST_PICKED)) |->
      ($past(state_ff) == gbsp_pkg::S_REPORT))
      else $error("picked response without a finished scan");

   a_pick_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.op == gbsp_pkg::OP_PICK)) |=> (busy || rsp_strobe))
      else $error("pick request neither started nor answered");

endmodule
